### src/gasp_pkg.sv
`default_nettype none
package gasp_pkg;
   localparam int GridW = 8;
   localparam int GridH = 8;
   localparam int Cells = GridW * GridH;
   localparam int XW = 3;
   localparam int YW = 3;
   localparam int CW = XW + YW;
   localparam int PW = 7;
   localparam int LW = 6;

   localparam logic [1:0] DirPy = 2'd0;
   localparam logic [1:0] DirPx = 2'd1;
   localparam logic [1:0] DirNy = 2'd2;
   localparam logic [1:0] DirNx = 2'd3;

   localparam logic [1:0] StateFree = 2'd2;

   // Floor of the Euclidean distance, taken from a small square table.
   function automatic logic [3:0] est_f(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                        input logic [XW-1:0] gx, input logic [YW-1:0] gy);
      logic [XW-1:0] dx;
      logic [YW-1:0] dy;
      logic [7:0] s;
      logic [3:0] r;
      dx = (x > gx) ? (x - gx) : (gx - x);
      dy = (y > gy) ? (y - gy) : (gy - y);
      s = 8'(dx * dx) + 8'(dy * dy);
      r = 4'd0;
      for (int i = 1; i < 11; i++) begin
         if (8'(i * i) <= s) r = 4'(i);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

### src/grid_astar_path_search_core.sv
`default_nettype none
// Grid A* path search core, 8 x 8 cells, 4-connected.
// Requests arrive on the req_ channel under valid/stall. A request with
// req_action 0 writes one cell state into the map; loads stream at one per
// cycle while the core is idle. A request with req_action 1 runs a search
// from start to goal; the core then stalls the request channel until the
// last response of that search has been taken.
// The search keeps cell state in a map memory (one synchronous read port)
// and a node memory holding level, priority, parent and open/closed marks.
// Each expansion scans all 64 node entries for the minimum priority (ties to
// the lowest index), then selects the best open cell, closes it, reads and
// updates each in-grid neighbour in turn and finishes. The path walk then
// emits one response per step, from the goal back to the start.
// Open and closed marks carry an epoch number, so a search clears nothing;
// after 254 searches a sweep of the node memory runs before the next
// request is taken.
// Reset is synchronous and active high; a sweep empties the map and
// the node memory while requests are stalled, then the core idles.
// While the receiver stalls rsp_, the held response stays stable and the
// path walk waits.
module grid_astar_path_search_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_action,
   input  wire  [2:0]  req_cell_x,
   input  wire  [2:0]  req_cell_y,
   input  wire  [1:0]  req_cell_state,
   input  wire  [2:0]  req_start_x,
   input  wire  [2:0]  req_start_y,
   input  wire  [2:0]  req_goal_x,
   input  wire  [2:0]  req_goal_y,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_move_dir,
   output logic        rsp_has_move,
   output logic        rsp_found,
   output logic        rsp_last
);
   localparam int CW = gasp_pkg::CW;
   localparam int PW = gasp_pkg::PW;
   localparam int LW = gasp_pkg::LW;
   localparam int EW = 8;

   typedef enum logic [8:0] {
      S_CLR  = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_SCAN = 9'b000000100,
      S_SEL  = 9'b000001000,
      S_NRD  = 9'b000010000,
      S_NWR  = 9'b000100000,
      S_WALK = 9'b001000000,
      S_WRD  = 9'b010000000,
      S_OUT  = 9'b100000000
   } st_type;

   // Node entry: open and closed are valid only when their epoch matches.
   typedef struct packed {
      logic [EW-1:0] oep;
      logic [EW-1:0] cep;
      logic [PW-1:0] pri;
      logic [LW-1:0] lvl;
      logic [1:0]    par;
   } node_type;

   st_type st_ff, st_in;
   logic [CW:0] cnt_ff, cnt_in;
   logic [EW-1:0] ep_ff, ep_in;
   logic mclr_ff, mclr_in;
   logic [2:0] sx_ff, sy_ff, gx_ff, gy_ff;
   logic [2:0] sx_in, sy_in, gx_in, gy_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [LW-1:0] clvl_ff, clvl_in;
   logic [CW-1:0] best_ff, best_in;
   logic [PW-1:0] bpri_ff, bpri_in;
   logic bval_ff, bval_in;
   logic [2:0] dir_ff, dir_in;
   logic [CW-1:0] nb_ff, nb_in;
   logic rv_ff, rv_in;
   logic [1:0] rd_ff, rd_in;
   logic rm_ff, rm_in, rf_ff, rf_in, rl_ff, rl_in;

   node_type nmem [gasp_pkg::Cells];
   node_type nrd;
   logic [CW-1:0] naddr;
   logic nwe;
   logic [CW-1:0] nwaddr;
   node_type nwdata;

   logic mwe;
   logic [CW-1:0] mwaddr, maddr;
   logic [1:0] mwdata, mrd;

   gasp_map_ram u_map (
      .clock(clock), .wr_en(mwe), .wr_addr(mwaddr), .wr_data(mwdata),
      .rd_addr(maddr), .rd_data(mrd)
   );

   always_ff @(posedge clock) begin
      if (nwe) nmem[nwaddr] <= nwdata;
      nrd <= nmem[naddr];
   end

   logic acc;
   logic ep_last;
   logic [CW-1:0] goal_c, start_c;
   logic [2:0] nx, ny, cx, cy;
   logic nb_in_grid;
   logic [1:0] d2;
   logic [CW-1:0] scan_idx;
   logic is_open, is_closed;
   logic [LW-1:0] nlvl;
   logic [PW-1:0] npri;

   assign goal_c   = {gy_ff, gx_ff};
   assign start_c  = {sy_ff, sx_ff};
   assign cx       = cur_ff[2:0];
   assign cy       = cur_ff[5:3];
   assign req_stall = (st_ff != S_IDLE) || rv_ff;
   assign acc      = req_valid && !req_stall;
   // The last usable epoch; the search that used it ends in a node sweep.
   assign ep_last  = (ep_ff == '1 - EW'(1));
   assign scan_idx = cnt_ff[CW-1:0];
   assign d2       = dir_ff[1:0];
   assign is_open   = (nrd.oep == ep_ff);
   assign is_closed = (nrd.cep == ep_ff);
   assign nlvl     = clvl_ff + LW'(1);
   assign npri     = PW'(nlvl) + PW'(gasp_pkg::est_f(nb_ff[2:0], nb_ff[5:3], gx_ff, gy_ff));

   always_comb begin
      nx = cx;
      ny = cy;
      nb_in_grid = 1'b1;
      case (d2)
         gasp_pkg::DirPy: begin ny = cy + 3'd1; nb_in_grid = (cy != 3'd7); end
         gasp_pkg::DirPx: begin nx = cx + 3'd1; nb_in_grid = (cx != 3'd7); end
         gasp_pkg::DirNy: begin ny = cy - 3'd1; nb_in_grid = (cy != 3'd0); end
         default:         begin nx = cx - 3'd1; nb_in_grid = (cx != 3'd0); end
      endcase
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; ep_in = ep_ff; mclr_in = mclr_ff;
      sx_in = sx_ff; sy_in = sy_ff; gx_in = gx_ff; gy_in = gy_ff;
      cur_in = cur_ff; clvl_in = clvl_ff; best_in = best_ff; bpri_in = bpri_ff;
      bval_in = bval_ff; dir_in = dir_ff; nb_in = nb_ff;
      rv_in = rv_ff && rsp_stall;
      rd_in = rd_ff; rm_in = rm_ff; rf_in = rf_ff; rl_in = rl_ff;
      naddr = scan_idx; nwe = 1'b0; nwaddr = cur_ff; nwdata = nrd;
      mwe = 1'b0; mwaddr = {req_cell_y, req_cell_x}; mwdata = req_cell_state;
      maddr = nb_ff;
      case (st_ff)
         S_CLR: begin
            // The map is swept only after reset; an epoch wrap sweeps nodes only.
            mwe = mclr_ff; mwaddr = scan_idx; mwdata = 2'd0;
            nwe = 1'b1; nwaddr = scan_idx;
            nwdata = '{oep: '1, cep: '1, pri: '0, lvl: '0, par: '0};
            cnt_in = cnt_ff + 1'b1;
            if (scan_idx == CW'(gasp_pkg::Cells - 1)) begin
               st_in = S_IDLE; ep_in = '0; mclr_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (acc && !req_action) mwe = 1'b1;
            if (acc && req_action) begin
               sx_in = req_start_x; sy_in = req_start_y;
               gx_in = req_goal_x; gy_in = req_goal_y;
               ep_in = ep_ff + 1'b1;
               if (ep_ff == '1 - EW'(1)) ep_in = '0;
               nwe = 1'b1; nwaddr = {req_start_y, req_start_x};
               nwdata.oep = (ep_ff == '1 - EW'(1)) ? '0 : ep_ff + 1'b1;
               nwdata.cep = '1;
               nwdata.lvl = '0; nwdata.par = '0;
               nwdata.pri = PW'(gasp_pkg::est_f(req_start_x, req_start_y,
                                                req_goal_x, req_goal_y));
               cnt_in = '0; bval_in = 1'b0; st_in = S_SCAN;
               naddr = '0;
            end
         end
         S_SCAN: begin
            // Read of entry cnt-1 is visible now; issue next read.
            naddr = CW'(cnt_ff);
            if (cnt_ff != '0) begin
               if (is_open && !is_closed && (!bval_ff || nrd.pri < bpri_ff)) begin
                  bval_in = 1'b1; bpri_in = nrd.pri; best_in = scan_idx - CW'(1);
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CW+1)'(gasp_pkg::Cells)) begin
               if (is_open && !is_closed && (!bval_ff || nrd.pri < bpri_ff)) begin
                  bval_in = 1'b1; bpri_in = nrd.pri; best_in = CW'(gasp_pkg::Cells - 1);
               end
               st_in = S_SEL;
               naddr = '0;
            end
         end
         S_SEL: begin
            naddr = best_ff;
            if (!bval_ff) begin
               rv_in = 1'b1; rd_in = '0; rm_in = 1'b0; rf_in = 1'b0; rl_in = 1'b1;
               cnt_in = '0;
               st_in = ep_last ? S_CLR : S_IDLE;
            end else begin
               cur_in = best_ff; st_in = S_NRD; dir_in = 3'd7;
            end
         end
         S_NRD: begin
            // dir 7 = close current, nrd holds the current entry; dir 4 = done.
            naddr = nb_ff;
            if (dir_ff == 3'd7) begin
               nwe = 1'b1; nwaddr = cur_ff;
               nwdata = nrd; nwdata.cep = ep_ff; nwdata.oep = '1; nwdata.pri = '0;
               clvl_in = nrd.lvl;
               if (cur_ff == goal_c) begin
                  cnt_in = '0;
                  if (cur_ff == start_c) begin
                     rv_in = 1'b1; rd_in = '0; rm_in = 1'b0; rf_in = 1'b1;
                     rl_in = 1'b1; st_in = ep_last ? S_CLR : S_IDLE;
                  end else begin
                     st_in = S_WALK; naddr = cur_ff;
                  end
               end else begin
                  dir_in = 3'd0; st_in = S_NRD; nb_in = nb_ff;
               end
            end else if (dir_ff[2]) begin
               cnt_in = '0; bval_in = 1'b0; st_in = S_SCAN; naddr = '0;
            end else if (!nb_in_grid) begin
               dir_in = dir_ff + 3'd1;
            end else begin
               nb_in = {ny, nx}; naddr = {ny, nx}; maddr = {ny, nx}; st_in = S_NWR;
            end
         end
         S_NWR: begin
            // Node entry and map state of the neighbour are visible now.
            naddr = nb_ff;
            if ((nb_ff == goal_c) || (mrd == gasp_pkg::StateFree && !is_closed)) begin
               if (!is_open || nrd.pri > npri) begin
                  nwe = 1'b1; nwaddr = nb_ff;
                  nwdata = nrd; nwdata.oep = ep_ff; nwdata.pri = npri;
                  nwdata.lvl = nlvl; nwdata.par = d2 + 2'd2;
               end
            end
            dir_in = dir_ff + 3'd1; st_in = S_NRD;
         end
         S_WALK: begin
            naddr = cur_ff; st_in = S_WRD;
         end
         S_WRD: begin
            naddr = cur_ff;
            if (!rv_ff || !rsp_stall) begin
               logic [2:0] px, py;
               logic ok;
               logic [CW-1:0] nxt;
               px = cur_ff[2:0]; py = cur_ff[5:3]; ok = 1'b1;
               case (nrd.par)
                  gasp_pkg::DirPy: begin py = py + 3'd1; ok = (cur_ff[5:3] != 3'd7); end
                  gasp_pkg::DirPx: begin px = px + 3'd1; ok = (cur_ff[2:0] != 3'd7); end
                  gasp_pkg::DirNy: begin py = py - 3'd1; ok = (cur_ff[5:3] != 3'd0); end
                  default:         begin px = px - 3'd1; ok = (cur_ff[2:0] != 3'd0); end
               endcase
               nxt = {py, px};
               rv_in = 1'b1; rd_in = nrd.par + 2'd2; rm_in = 1'b1; rf_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               rl_in = !ok || (nxt == start_c) || (cnt_ff == (CW+1)'(gasp_pkg::Cells - 1));
               if (rl_in) st_in = S_OUT;
               else begin cur_in = nxt; naddr = nxt; st_in = S_WRD; end
               if (!rl_in) st_in = S_WALK;
            end
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               cnt_in = '0;
               st_in = ep_last ? S_CLR : S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; cnt_ff <= '0; ep_ff <= '0; rv_ff <= 1'b0; bval_ff <= 1'b0;
         mclr_ff <= 1'b1;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ep_ff <= ep_in; rv_ff <= rv_in;
         bval_ff <= bval_in; mclr_ff <= mclr_in;
      end
      sx_ff <= sx_in; sy_ff <= sy_in; gx_ff <= gx_in; gy_ff <= gy_in;
      cur_ff <= cur_in; clvl_ff <= clvl_in; best_ff <= best_in; bpri_ff <= bpri_in;
      dir_ff <= dir_in; nb_ff <= nb_in;
      rd_ff <= rd_in; rm_ff <= rm_in; rf_ff <= rf_in; rl_ff <= rl_in;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_move_dir = rd_ff;
   assign rsp_has_move = rm_ff;
   assign rsp_found    = rf_ff;
   assign rsp_last     = rl_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   a_move_found: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rm_ff) |-> rf_ff) else $error("move without route");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rd_ff) && $stable(rl_ff)))
      else $error("stalled response changed");
endmodule
`default_nettype wire

### src/gasp_map_ram.sv
`default_nettype none
module gasp_map_ram (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [gasp_pkg::CW-1:0]   wr_addr,
   input  wire [1:0]                wr_data,
   input  wire [gasp_pkg::CW-1:0]   rd_addr,
   output logic [1:0]               rd_data
);
   logic [1:0] mem [gasp_pkg::Cells];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
